### hdl/cltok_pkg.sv
// Shared types, byte codes and event codes of the command line tokenizer.
package cltok_pkg;

  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [3:0] {
    EV_CMD_CHAR    = 4'd0,
    EV_CMD_END     = 4'd1,
    EV_ARG_CHAR    = 4'd2,
    EV_ARG_END     = 4'd3,
    EV_FLAG_CHAR   = 4'd4,
    EV_FLAG_END    = 4'd5,
    EV_KEY_CHAR    = 4'd6,
    EV_KEY_DROPPED = 4'd7,
    EV_VAL_CHAR    = 4'd8,
    EV_VAL_END     = 4'd9,
    EV_KEY_END_VAL = 4'd10,
    EV_KEY_END     = 4'd11,
    EV_BLANK       = 4'd12
  } cltok_event_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_line;
  } cltok_in_t;

  typedef struct packed {
    logic [3:0] event_res;
    logic [7:0] char_out;
    logic       done_res;
  } cltok_out_t;

  typedef struct packed {
    logic in_command_word;
    logic in_key_name;
    logic in_key_value;
    logic in_flag_token;
    logic in_argument;
    logic inside_brackets;
    logic escape_pending;
    logic at_line_start;
    logic key_nonempty;
    logic value_nonempty;
  } cltok_state_t;

  localparam cltok_state_t CLTOK_STATE_RESET = '{
    in_command_word: 1'b1,
    in_key_name:     1'b0,
    in_key_value:    1'b0,
    in_flag_token:   1'b0,
    in_argument:     1'b0,
    inside_brackets: 1'b0,
    escape_pending:  1'b0,
    at_line_start:   1'b1,
    key_nonempty:    1'b0,
    value_nonempty:  1'b0
  };

endpackage

### hdl/cltok_step.sv
// Per-byte classification logic: next tokenizer state and the result of one item.
module cltok_step import cltok_pkg::*; (
  input  cltok_state_t state,
  input  cltok_in_t    item,
  output cltok_state_t state_next,
  output logic         emit,
  output cltok_out_t   result
);

  logic [7:0]   c;
  logic         plain_space;
  cltok_state_t n;
  cltok_event_t ev;

  assign c           = item.end_of_line ? CH_SPACE : item.ch;
  assign plain_space = (c == CH_SPACE) && !state.inside_brackets;

  always_comb begin
    n                 = state;
    n.at_line_start   = 1'b0;
    emit              = 1'b0;
    ev                = EV_BLANK;
    if (state.at_line_start && (c == CH_SLASH)) begin
      emit = 1'b0;
    end else if ((c inside {CH_LBRACK, CH_RBRACK}) && !state.escape_pending) begin
      n.inside_brackets = (c == CH_LBRACK);
    end else if ((c == CH_DOLLAR) && !state.escape_pending) begin
      n.escape_pending = 1'b1;
    end else begin
      n.escape_pending = 1'b0;
      emit             = 1'b1;
      if (state.in_command_word) begin
        if (plain_space) begin
          n.in_command_word = 1'b0;
          ev                = EV_CMD_END;
        end else begin
          ev = EV_CMD_CHAR;
        end
      end else if (plain_space) begin
        if (state.in_argument) begin
          ev = EV_ARG_END;
        end else if (state.in_flag_token) begin
          ev = EV_FLAG_END;
        end else if (state.in_key_value) begin
          ev = state.value_nonempty ? EV_VAL_END : EV_KEY_END;
        end else if (state.in_key_name) begin
          ev = EV_KEY_DROPPED;
        end else begin
          ev = EV_BLANK;
        end
        n.in_argument    = 1'b0;
        n.in_flag_token  = 1'b0;
        n.in_key_value   = 1'b0;
        n.in_key_name    = 1'b0;
        n.key_nonempty   = 1'b0;
        n.value_nonempty = 1'b0;
      end else if (!state.in_key_name && !state.in_flag_token && !state.in_key_value &&
                   !state.value_nonempty) begin
        if ((c == CH_PLUS) && !state.inside_brackets) begin
          n.in_key_name = 1'b1;
          emit          = 1'b0;
        end else if ((c == CH_MINUS) && !state.inside_brackets) begin
          n.in_flag_token = 1'b1;
          emit            = 1'b0;
        end else begin
          n.in_argument    = 1'b1;
          n.value_nonempty = 1'b1;
          ev               = EV_ARG_CHAR;
        end
      end else if (state.key_nonempty && !state.inside_brackets &&
                   (c inside {CH_COLON, CH_COMMA})) begin
        if (state.in_key_name) begin
          ev = EV_KEY_END_VAL;
        end else begin
          ev = state.value_nonempty ? EV_VAL_END : EV_BLANK;
        end
        n.in_key_name    = 1'b0;
        n.in_key_value   = 1'b1;
        n.value_nonempty = 1'b0;
      end else if (state.in_key_name) begin
        n.key_nonempty = 1'b1;
        ev             = EV_KEY_CHAR;
      end else begin
        n.value_nonempty = 1'b1;
        if (state.in_flag_token) begin
          ev = EV_FLAG_CHAR;
        end else if (state.in_key_value) begin
          ev = EV_VAL_CHAR;
        end else begin
          ev = EV_ARG_CHAR;
        end
      end
    end
    if (item.end_of_line) begin
      n = CLTOK_STATE_RESET;
    end
  end

  assign state_next       = n;
  assign result.event_res = ev;
  assign result.char_out  = c;
  assign result.done_res  = item.end_of_line;

endmodule

### hdl/cltok_out_reg.sv
// Result register: holds one result transaction until the consumer takes it.
module cltok_out_reg import cltok_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  cltok_out_t load_data,
  output logic       free,
  output logic       out_valid,
  input  logic       out_ready,
  output cltok_out_t out_data
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      out_data <= load_data;
    end
  end

endmodule

### hdl/command_line_tokenizer.sv
// Top level of the command line tokenizer: input register, state register and result register.
// Accepts one byte transaction per cycle and gives at most one result for each; a byte is
// held in the input register, its result in the result register, with the classification
// and state update done between the two. Skipped bytes (a leading '/', unescaped brackets
// and '$', and the '+' or '-' that opens a key or flag) give no result. The terminator
// transaction always gives one result with done_res set and returns the tokenizer to its
// reset state. The state and result registers, and the input register once it holds a
// byte, stall when a result waits in the result register and the consumer holds out_ready low.
module command_line_tokenizer import cltok_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  cltok_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output cltok_out_t out_data
);

  logic         in_q_valid;
  cltok_in_t    in_q;
  cltok_state_t state;
  cltok_state_t state_next;
  logic         emit;
  cltok_out_t   result;
  logic         out_free;
  logic         advance;

  assign advance  = in_q_valid && out_free;
  assign in_ready = !in_q_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_q <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CLTOK_STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

  cltok_step u_step (
    .state      (state),
    .item       (in_q),
    .state_next (state_next),
    .emit       (emit),
    .result     (result)
  );

  cltok_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && emit),
    .load_data (result),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_eol_emits: assert property (@(posedge clk) disable iff (rst)
    advance && in_q.end_of_line |-> emit)
    else $error("terminator transaction gave no result");

  a_eol_resets: assert property (@(posedge clk) disable iff (rst)
    advance && in_q.end_of_line |=> state == CLTOK_STATE_RESET)
    else $error("state not back to reset after terminator");

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    state.in_command_word |-> !(state.in_key_name || state.in_flag_token ||
                                state.in_key_value || state.in_argument))
    else $error("command word overlaps another token kind");

endmodule
